### hdl/lgcb_pkg.sv
// Package for the loudness gain curve builder.
// Holds the word structs, the job descriptor, status and register codes.
// No dependencies.
package lgcb_pkg;

  // Job count field covers point stores of up to 127 points
  localparam int CNT_W = 7;

  localparam logic [17:0] ONE_KHZ = 18'd10000;
  localparam logic [17:0] BAND_LO = 18'd200;
  localparam logic [17:0] BAND_HI = 18'd125000;

  localparam logic [16:0] STRENGTH_RST  = 17'd65536;
  localparam logic [11:0] MAX_BOOST_RST = 12'd3072;
  localparam logic [17:0] ROLLOFF_RST   = 18'd0;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LIMITED   = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NO_ANCHOR = 3'd3;
  localparam logic [2:0] ST_MISALIGN  = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_STRENGTH  = 2'd0;
  localparam logic [1:0] REG_MAX_BOOST = 2'd1;
  localparam logic [1:0] REG_ROLLOFF   = 2'd2;

  typedef struct packed {
    logic [17:0]        point_freq;
    logic [17:0]        ref_point_freq;
    logic signed [15:0] current_level;
    logic signed [15:0] reference_level;
    logic               is_last;
  } point_t;

  typedef struct packed {
    logic [17:0]        out_freq;
    logic signed [15:0] gain;
    logic               point_limited;
    logic [2:0]         status;
    logic               end_of_curve;
  } result_t;

  // One stored contour point
  typedef struct packed {
    logic [17:0]        freq;
    logic signed [15:0] cur_level;
    logic signed [15:0] ref_level;
  } mem_word_t;

  // Curve descriptor handed from front to back
  typedef struct packed {
    logic [2:0]         status;
    logic [CNT_W-1:0]   count;
    logic signed [15:0] cur_anchor;
    logic signed [15:0] ref_anchor;
  } job_t;

  typedef struct packed {
    logic [16:0] strength;
    logic [11:0] max_boost;
    logic [17:0] rolloff;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_ERR
  } back_state_t;

endpackage

### hdl/lgcb_front.sv
// Front end: accepts contour points, stores them, tracks anchors and errors.
// Emits one job descriptor per curve. Depends on lgcb_pkg.
module lgcb_front
  import lgcb_pkg::*;
#(
  parameter int MAX_POINTS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  point_t    point,
  output logic      push,
  output job_t      job,
  input  logic      rd_en,
  input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output mem_word_t rd_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  mem_word_t mem [MAX_POINTS];

  logic [CW-1:0]      count;
  logic               ovf;
  logic               mis;
  logic               cur_found;
  logic               ref_found;
  logic signed [15:0] cur_anchor;
  logic signed [15:0] ref_anchor;

  logic               stored;
  logic [CW-1:0]      count_f;
  logic               ovf_f;
  logic               mis_f;
  logic               cur_hit;
  logic               ref_hit;
  logic signed [15:0] cur_anchor_f;
  logic signed [15:0] ref_anchor_f;

  // Classify the incoming point against the running curve state
  always_comb begin
    stored       = accept && (count != CW'(MAX_POINTS));
    count_f      = stored ? count + CW'(1) : count;
    ovf_f        = ovf || (accept && !stored);
    mis_f        = mis || (stored && (point.point_freq != point.ref_point_freq));
    cur_hit      = stored && !cur_found && (point.point_freq == ONE_KHZ);
    ref_hit      = stored && !ref_found && (point.ref_point_freq == ONE_KHZ);
    cur_anchor_f = cur_hit ? point.current_level : cur_anchor;
    ref_anchor_f = ref_hit ? point.reference_level : ref_anchor;
    push         = accept && point.is_last;
    job.count      = CNT_W'(count_f);
    job.cur_anchor = cur_anchor_f;
    job.ref_anchor = ref_anchor_f;
    if (ovf_f || (count_f == '0)) begin
      job.status = ST_EMPTY;
    end else if (!(cur_found || cur_hit) || !(ref_found || ref_hit)) begin
      job.status = ST_NO_ANCHOR;
    end else if (mis_f) begin
      job.status = ST_MISALIGN;
    end else begin
      job.status = ST_OK;
    end
  end

  // Curve state; cleared after the final point
  always_ff @(posedge clk) begin
    if (rst || push) begin
      count      <= '0;
      ovf        <= 1'b0;
      mis        <= 1'b0;
      cur_found  <= 1'b0;
      ref_found  <= 1'b0;
      cur_anchor <= '0;
      ref_anchor <= '0;
    end else if (accept) begin
      count      <= count_f;
      ovf        <= ovf_f;
      mis        <= mis_f;
      cur_found  <= cur_found || cur_hit;
      ref_found  <= ref_found || ref_hit;
      cur_anchor <= cur_anchor_f;
      ref_anchor <= ref_anchor_f;
    end
  end

  // Point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (stored) begin
      mem[count[AW-1:0]] <= '{freq:      point.point_freq,
                              cur_level: point.current_level,
                              ref_level: point.reference_level};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    push |=> (count == '0) && !ovf && !cur_found && !ref_found)
    else $error("curve state not cleared after final point");
`endif

endmodule

### hdl/lgcb_job_fifo.sv
// Two-entry queue of job descriptors between front and back.
// Depends on lgcb_pkg.
module lgcb_job_fifo
  import lgcb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] level;
  logic       full;

  assign empty   = (level == 2'd0);
  assign full    = (level == 2'd2);
  assign pop_job = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      level <= level + 2'(push) - 2'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("job queue underrun");
`endif

endmodule

### hdl/lgcb_back.sv
// Back end: walks the stored points of a job, computes and limits each gain.
// Reads the point store in lgcb_front. Depends on lgcb_pkg.
module lgcb_back
  import lgcb_pkg::*;
#(
  parameter int MAX_POINTS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      job_empty,
  input  job_t      job_in,
  output logic      pop,
  output logic      rd_en,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  mem_word_t rd_data,
  output logic      active,
  output logic      result_strobe,
  output result_t   result
);

  localparam int AW = $clog2(MAX_POINTS);

  back_state_t state;
  back_state_t state_next;
  job_t        job;
  logic [CNT_W-1:0] idx;
  logic        issue_last;
  logic        err_emit;

  // Pipeline registers
  logic               v1, v2, v3;
  logic               last1, last2, last3;
  logic signed [17:0] diff2;
  logic [17:0]        freq2, freq3;
  logic signed [35:0] prod3;
  logic               any_lim;

  assign issue_last = (idx == job.count - CNT_W'(1));
  assign rd_addr    = idx[AW-1:0];
  assign active     = (state != BK_IDLE) || v1 || v2 || v3;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          state_next = (job_in.status != ST_OK) ? BK_ERR : BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue_last) begin
          state_next = BK_IDLE;
        end
      end
      BK_ERR:  state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    err_emit = 1'b0;
    case (state)
      BK_IDLE: pop      = !job_empty;
      BK_RUN:  rd_en    = 1'b1;
      BK_ERR:  err_emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Job latch and read index
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= job_in;
      idx <= '0;
    end else if (rd_en) begin
      idx <= idx + CNT_W'(1);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Difference against anchors, then scale by strength
  always_ff @(posedge clk) begin
    last1 <= issue_last;
    last2 <= last1;
    last3 <= last2;
    freq2 <= rd_data.freq;
    freq3 <= freq2;
    diff2 <= ({{2{rd_data.cur_level[15]}}, rd_data.cur_level}
              - {{2{job.cur_anchor[15]}}, job.cur_anchor})
           - ({{2{rd_data.ref_level[15]}}, rd_data.ref_level}
              - {{2{job.ref_anchor[15]}}, job.ref_anchor});
    prod3 <= diff2 * $signed({1'b0, cfg.strength});
  end

  // Rounding and limits
  logic signed [35:0] rounded;
  logic signed [19:0] g;
  logic               lim;

  always_comb begin
    rounded = prod3 + 36'sd32768;
    g       = rounded[35:16];
    lim     = 1'b0;
    if ((freq3 < BAND_LO) || (freq3 > BAND_HI)) begin
      g   = '0;
      lim = 1'b1;
    end
    if ((cfg.rolloff != '0) && (freq3 < cfg.rolloff) && (g > 20'sd0)) begin
      g   = '0;
      lim = 1'b1;
    end
    if (g > $signed({8'd0, cfg.max_boost})) begin
      g   = $signed({8'd0, cfg.max_boost});
      lim = 1'b1;
    end
    if (g < -20'sd32768) begin
      g = -20'sd32768;
    end
  end

  // Limited-point tracking over one curve
  always_ff @(posedge clk) begin
    if (rst || pop) begin
      any_lim <= 1'b0;
    end else if (v3 && lim) begin
      any_lim <= 1'b1;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= v3 || err_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (err_emit) begin
      result <= '{out_freq: '0, gain: '0, point_limited: 1'b0,
                  status: job.status, end_of_curve: 1'b1};
    end else if (v3) begin
      result.out_freq      <= freq3;
      result.gain          <= g[15:0];
      result.point_limited <= lim;
      result.status        <= (last3 && (any_lim || lim)) ? ST_LIMITED : ST_OK;
      result.end_of_curve  <= last3;
    end
  end

`ifndef SYNTH
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (state == BK_ERR) |=> result_strobe && result.end_of_curve
                          && (result.status != ST_OK))
    else $error("error word not emitted");
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(v3 && err_emit))
    else $error("gain word and error word collide");
`endif

endmodule

### hdl/loudness_gain_curve_builder.sv
// Loudness gain curve builder: point loading at one point per cycle while
// busy is low. After the final point, its job passes the job queue and the
// gain words follow, registered, one word per cycle; a failed job gives an
// error word instead. busy is high from the final point until the last word
// is registered.
// rst (sync, high) clears control state and config registers; no point store or data path reset.
module loudness_gain_curve_builder
  import lgcb_pkg::*;
#(
  parameter int MAX_POINTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  point_t      point,
  output logic        result_strobe,
  output result_t     result,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [17:0] wr_data
);

  localparam int AW = $clog2(MAX_POINTS);

  cfg_t      cfg;
  logic      accept;
  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      pop_job;
  logic      job_empty;
  logic      rd_en;
  logic [AW-1:0] rd_addr;
  mem_word_t rd_data;
  logic      back_active;

  assign accept = start && !busy;
  assign busy   = !job_empty || back_active;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{strength: STRENGTH_RST, max_boost: MAX_BOOST_RST,
               rolloff: ROLLOFF_RST};
    end else if (wr_en) begin
      case (wr_index)
        REG_STRENGTH:  cfg.strength  <= wr_data[16:0];
        REG_MAX_BOOST: cfg.max_boost <= wr_data[11:0];
        REG_ROLLOFF:   cfg.rolloff   <= wr_data;
        default: ;
      endcase
    end
  end

  lgcb_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .point   (point),
    .push    (push),
    .job     (push_job),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lgcb_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (job_empty)
  );

  lgcb_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .job_empty     (job_empty),
    .job_in        (pop_job),
    .pop           (pop),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .active        (back_active),
    .result_strobe (result_strobe),
    .result        (result)
  );

`ifndef SYNTH
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && point.is_last) |=> busy)
    else $error("block idle right after final point");
`endif

endmodule
